// ===== rtl/esc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the environmental sensor compensation block.
package esc_pkg;

  localparam int DW = 64;

  localparam logic [23:0] RAW_SKIP24 = 24'h800000;
  localparam logic [15:0] RAW_SKIP16 = 16'h8000;

  localparam logic [2:0] REG_TCAL      = 3'd0;
  localparam logic [2:0] REG_PCAL_LO   = 3'd1;
  localparam logic [2:0] REG_PCAL_HI   = 3'd2;
  localparam logic [2:0] REG_PCAL_LAST = 3'd3;
  localparam logic [2:0] REG_HCAL      = 3'd4;

  localparam logic [1:0] PST_OK   = 2'd0;
  localparam logic [1:0] PST_SKIP = 2'd1;
  localparam logic [1:0] PST_DIVZ = 2'd2;

  localparam logic [28:0] HUM_MAX_Q10 = 29'd419430400;

  typedef struct packed {
    logic [15:0] temp;
    logic [13:0] hum;
    logic [1:0]  status;
  } esc_side_t;

endpackage

// ===== rtl/esc_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
module esc_div import esc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  esc_side_t     in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quot,
  output esc_side_t     out_side
);

  logic [DW-1:0] rem_r  [0:DW];
  logic [DW-1:0] quo_r  [0:DW];
  logic [DW-1:0] den_r  [0:DW];
  logic          neg_r  [0:DW];
  logic          vld_r  [0:DW];
  esc_side_t     side_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= in_num[DW-1] ? (~in_num + 1'b1) : in_num;
      den_r[0]  <= in_den[DW-1] ? (~in_den + 1'b1) : in_den;
      neg_r[0]  <= in_num[DW-1] ^ in_den[DW-1];
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem_r[k], quo_r[k][DW-1]};
    assign diff = t - {1'b0, den_r[k]};
    assign ge   = (t >= {1'b0, den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        quo_r[k+1]  <= {quo_r[k][DW-2:0], ge};
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[DW];
  assign out_quot  = neg_r[DW] ? (~quo_r[DW] + 1'b1) : quo_r[DW];
  assign out_side  = side_r[DW];

endmodule

// ===== rtl/env_sensor_compensation.sv =====
`timescale 1ns / 1ps
// Environmental sensor compensation top level: integer temperature, pressure, humidity.
//
// Input stream (in_*): one item is a set of raw temperature, pressure and humidity
// readings. Output stream (out_*): one item per input item, in order, holding
// temperature in 0.01 degC, pressure in Pa, humidity in 0.01 %RH and a pressure
// status (valid, reading skipped, zero divisor).
// Calibration words are written over the cfg_ APB port (8-byte register stride)
// and must only change while no item is in flight.
// Throughput is one item per cycle while out_tready stays high. From acceptance to
// out_tvalid an item passes nine arithmetic stages, the 65-stage divider (one
// quotient bit per stage), five stages of pressure correction and the output register.
// A two-entry output register plus skid buffer decouples the receiver: while
// out_tready is low one more item is absorbed, after which in_tready drops and
// the whole pipeline holds. Reset clears all valid flags and the calibration
// registers; no item is lost or repeated across a stall.
module env_sensor_compensation import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_temperature[23:0], raw_pressure[47:24], raw_humidity[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // temperature_centi[15:0], pressure_pa[47:16],
                                  // humidity_centi[61:48], pressure_status[63:62]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration
  logic [47:0] tcal_r;
  logic [63:0] pcal_lo_r, pcal_hi_r, hcal_r;
  logic [15:0] pcal_last_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r      <= '0;
      pcal_lo_r   <= '0;
      pcal_hi_r   <= '0;
      pcal_last_r <= '0;
      hcal_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[5:3])
        REG_TCAL:      tcal_r      <= cfg_pwdata[47:0];
        REG_PCAL_LO:   pcal_lo_r   <= cfg_pwdata;
        REG_PCAL_HI:   pcal_hi_r   <= cfg_pwdata;
        REG_PCAL_LAST: pcal_last_r <= cfg_pwdata[15:0];
        REG_HCAL:      hcal_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      REG_TCAL:      cfg_prdata = 64'(tcal_r);
      REG_PCAL_LO:   cfg_prdata = pcal_lo_r;
      REG_PCAL_HI:   cfg_prdata = pcal_hi_r;
      REG_PCAL_LAST: cfg_prdata = 64'(pcal_last_r);
      REG_HCAL:      cfg_prdata = hcal_r;
      default:       cfg_prdata = '0;
    endcase
  end

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic        [7:0]  h1, h3;
  logic signed [7:0]  h6;
  logic signed [11:0] h5;
  logic        [11:0] h4;

  assign t1 = tcal_r[15:0];
  assign t2 = $signed(tcal_r[31:16]);
  assign t3 = $signed(tcal_r[47:32]);
  assign p1 = pcal_lo_r[15:0];
  assign p2 = $signed(pcal_lo_r[31:16]);
  assign p3 = $signed(pcal_lo_r[47:32]);
  assign p4 = $signed(pcal_lo_r[63:48]);
  assign p5 = $signed(pcal_hi_r[15:0]);
  assign p6 = $signed(pcal_hi_r[31:16]);
  assign p7 = $signed(pcal_hi_r[47:32]);
  assign p8 = $signed(pcal_hi_r[63:48]);
  assign p9 = $signed(pcal_last_r);
  assign h1 = hcal_r[7:0];
  assign h2 = $signed(hcal_r[23:8]);
  assign h3 = hcal_r[31:24];
  assign h4 = hcal_r[43:32];
  assign h5 = $signed(hcal_r[55:44]);
  assign h6 = $signed(hcal_r[63:56]);

  // flow control
  logic        adv;
  logic        out_valid_r, skid_valid_r;
  logic [63:0] out_data_r, skid_data_r;

  assign adv       = !skid_valid_r;
  assign in_tready = adv;

  // stage 1: temperature products
  logic [23:0]        in_rt, in_rp;
  logic [15:0]        in_rh;
  logic signed [17:0] s1_x1_nxt;
  logic signed [16:0] s1_d_nxt;
  logic signed [33:0] s1_m1_nxt, s1_dd_nxt;

  assign in_rt     = in_tdata[23:0];
  assign in_rp     = in_tdata[47:24];
  assign in_rh     = in_tdata[63:48];
  assign s1_x1_nxt = $signed({1'b0, in_rt[23:7]}) - $signed({1'b0, t1, 1'b0});
  assign s1_d_nxt  = $signed({1'b0, in_rt[23:8]}) - $signed({1'b0, t1});
  assign s1_m1_nxt = s1_x1_nxt * t2;
  assign s1_dd_nxt = s1_d_nxt * s1_d_nxt;

  logic        s1_vld_r, s1_skt_r, s1_skp_r, s1_skh_r;
  logic [31:0] s1_m1_r, s1_dd_r;
  logic [19:0] s1_rp_r;
  logic [15:0] s1_rh_r;

  // stage 2
  logic signed [35:0] s2_m2_nxt;
  assign s2_m2_nxt = $signed(s1_dd_r[31:12]) * t3;

  logic               s2_vld_r, s2_skt_r, s2_skp_r, s2_skh_r;
  logic signed [20:0] s2_v1_r;
  logic [31:0]        s2_m2_r;
  logic [19:0]        s2_rp_r;
  logic [15:0]        s2_rh_r;

  // stage 3: fine temperature
  logic signed [21:0] s3_tf_nxt;
  assign s3_tf_nxt = s2_skt_r ? 22'sd0
                   : 22'(s2_v1_r) + 22'($signed(s2_m2_r[31:14]));

  logic               s3_vld_r, s3_skp_r, s3_skh_r;
  logic signed [21:0] s3_tf_r;
  logic [19:0]        s3_rp_r;
  logic [15:0]        s3_rh_r;

  // stage 4
  logic signed [24:0] s4_t5;
  logic signed [22:0] s4_a, s4_hv;
  logic signed [45:0] s4_aa;
  logic signed [38:0] s4_ap5, s4_ap2;
  logic signed [34:0] s4_hv5;
  logic signed [30:0] s4_vh6;
  logic signed [31:0] s4_vh3;

  assign s4_t5  = (25'(s3_tf_r) <<< 2) + 25'(s3_tf_r) + 25'sd128;
  assign s4_a   = 23'(s3_tf_r) - 23'sd128000;
  assign s4_aa  = s4_a * s4_a;
  assign s4_ap5 = s4_a * p5;
  assign s4_ap2 = s4_a * p2;
  assign s4_hv  = 23'(s3_tf_r) - 23'sd76800;
  assign s4_hv5 = s4_hv * h5;
  assign s4_vh6 = s4_hv * h6;
  assign s4_vh3 = s4_hv * $signed({1'b0, h3});

  logic               s4_vld_r, s4_skp_r, s4_skh_r;
  logic [15:0]        s4_temp_r;
  logic signed [45:0] s4_aa_r;
  logic signed [38:0] s4_ap5_r, s4_ap2_r;
  logic [31:0]        s4_hv5_r;
  logic signed [30:0] s4_vh6_r;
  logic signed [31:0] s4_vh3_r;
  logic [19:0]        s4_rp_r;
  logic [15:0]        s4_rh_r;

  // stage 5
  logic signed [61:0] s5_b1, s5_c1;
  logic [31:0]        s5_hsum;
  logic signed [41:0] s5_hb1;

  assign s5_b1   = s4_aa_r * p6;
  assign s5_c1   = s4_aa_r * p3;
  assign s5_hsum = 32'({s4_rh_r, 14'd0}) - {h4, 20'd0} - s4_hv5_r + 32'd16384;
  assign s5_hb1  = $signed(s4_vh6_r[30:10]) * ($signed(s4_vh3_r[31:11]) + 21'sd32768);

  logic               s5_vld_r, s5_skp_r, s5_skh_r;
  logic [15:0]        s5_temp_r;
  logic signed [61:0] s5_b1_r, s5_c1_r;
  logic signed [38:0] s5_ap5_r, s5_ap2_r;
  logic signed [16:0] s5_ha_r;
  logic [31:0]        s5_hb1_r;
  logic [19:0]        s5_rp_r;

  // stage 6
  logic [63:0]        s6_b, s6_a2;
  logic signed [22:0] s6_hx;
  logic signed [38:0] s6_hm;

  assign s6_b  = 64'(s5_b1_r) + (64'(s5_ap5_r) << 17) + (64'(p4) << 35);
  assign s6_a2 = 64'(s5_c1_r >>> 8) + (64'(s5_ap2_r) << 12);
  assign s6_hx = 23'($signed(s5_hb1_r[31:10])) + 23'sd2097152;
  assign s6_hm = s6_hx * h2;

  logic               s6_vld_r, s6_skp_r, s6_skh_r;
  logic [15:0]        s6_temp_r;
  logic [63:0]        s6_b_r, s6_a2_r;
  logic [31:0]        s6_hm_r;
  logic signed [16:0] s6_ha_r;
  logic [19:0]        s6_rp_r;

  // stage 7
  logic signed [56:0] s7_ax;
  logic signed [73:0] s7_a3;
  logic [20:0]        s7_p0;
  logic [63:0]        s7_num;
  logic [31:0]        s7_hm2;
  logic signed [34:0] s7_hv;

  assign s7_ax  = 57'($signed(s6_a2_r)) + 57'sd140737488355328;
  assign s7_a3  = s7_ax * $signed({1'b0, p1});
  assign s7_p0  = 21'd1048576 - {1'b0, s6_rp_r};
  assign s7_num = (64'(s7_p0) << 31) - s6_b_r;
  assign s7_hm2 = s6_hm_r + 32'd8192;
  assign s7_hv  = s6_ha_r * $signed(s7_hm2[31:14]);

  logic        s7_vld_r, s7_skp_r, s7_skh_r;
  logic [15:0] s7_temp_r;
  logic [63:0] s7_a3_r, s7_num_r;
  logic [31:0] s7_hv_r;

  // stage 8
  logic [63:0]        s8_numm;
  logic [1:0]         s8_st;
  logic signed [33:0] s8_qq;

  assign s8_numm = (s7_num_r << 11) + (s7_num_r << 10) + (s7_num_r << 5)
                 + (s7_num_r << 4) + (s7_num_r << 2) + s7_num_r;
  assign s8_st   = s7_skp_r ? PST_SKIP : ((s7_a3_r[63:33] == '0) ? PST_DIVZ : PST_OK);
  assign s8_qq   = $signed(s7_hv_r[31:15]) * $signed(s7_hv_r[31:15]);

  logic        s8_vld_r, s8_skh_r;
  logic [15:0] s8_temp_r;
  logic [63:0] s8_numm_r;
  logic [30:0] s8_den_r;
  logic [1:0]  s8_st_r;
  logic [31:0] s8_qq_r, s8_hv_r;

  // stage 9
  logic signed [33:0] s9_r;
  assign s9_r = $signed(s8_qq_r[31:7]) * $signed({1'b0, h1});

  logic        s9_vld_r, s9_skh_r;
  logic [15:0] s9_temp_r;
  logic [63:0] s9_numm_r;
  logic [30:0] s9_den_r;
  logic [1:0]  s9_st_r;
  logic [31:0] s9_r_r, s9_hv_r;

  // humidity finish, into the divider
  logic [31:0]        s10_v;
  logic signed [31:0] s10_sv;
  logic [28:0]        s10_hc;
  logic [23:0]        s10_h100;
  logic [13:0]        s10_hum;
  esc_side_t          div_side_in, div_side_out;
  logic               div_vld_out;
  logic [63:0]        div_quot;

  assign s10_v  = s9_hv_r - 32'($signed(s9_r_r[31:4]));
  assign s10_sv = $signed(s10_v);

  always_comb begin
    if (s10_sv < 0) begin
      s10_hc = '0;
    end else if (s10_sv > $signed({3'd0, HUM_MAX_Q10})) begin
      s10_hc = HUM_MAX_Q10;
    end else begin
      s10_hc = s10_v[28:0];
    end
  end

  assign s10_h100 = 24'(s10_hc[28:12]) * 24'd100;
  assign s10_hum  = s9_skh_r ? 14'd0 : s10_h100[23:10];

  assign div_side_in = '{temp: s9_temp_r, hum: s10_hum, status: s9_st_r};

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s9_vld_r),
    .in_num    (s9_numm_r),
    .in_den    (64'($signed(s9_den_r))),
    .in_side   (div_side_in),
    .out_valid (div_vld_out),
    .out_quot  (div_quot),
    .out_side  (div_side_out)
  );

  // pressure correction stages
  logic        d1_vld_r, d2_vld_r, d3_vld_r, d4_vld_r, fin_vld_r;
  esc_side_t   d1_side_r, d2_side_r, d3_side_r, d4_side_r;
  logic [63:0] d1_p_r, d2_p_r, d3_p_r, d4_p_r;

  logic signed [66:0] d2_m;
  logic signed [79:0] d2_pb;
  assign d2_m  = p9 * $signed(d1_p_r[63:13]);
  assign d2_pb = p8 * $signed(d1_p_r);

  logic [63:0] d2_m_r, d2_pb_r;

  logic [63:0] d3_e, d3_ll;
  logic [31:0] d3_c1, d3_c2;
  assign d3_e  = 64'($signed(d2_p_r[63:13]));
  assign d3_ll = 64'(d2_m_r[31:0]) * 64'(d3_e[31:0]);
  assign d3_c1 = d2_m_r[31:0] * d3_e[63:32];
  assign d3_c2 = d2_m_r[63:32] * d3_e[31:0];

  logic [63:0] d3_ll_r;
  logic [31:0] d3_c1_r, d3_c2_r;
  logic [44:0] d3_bb_r;

  logic [63:0] d4_m2_nxt;
  assign d4_m2_nxt = d3_ll_r + {d3_c1_r + d3_c2_r, 32'd0};

  logic [63:0] d4_m2_r;
  logic [44:0] d4_bb_r;

  logic [63:0] d5_s, d5_pf;
  logic [31:0] d5_press;
  assign d5_s     = d4_p_r + 64'($signed(d4_m2_r[63:25])) + 64'($signed(d4_bb_r));
  assign d5_pf    = 64'($signed(d5_s[63:8])) + (64'(p7) << 4);
  assign d5_press = (d4_side_r.status == PST_OK) ? d5_pf[39:8] : 32'd0;

  logic [63:0] fin_data_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      d3_vld_r  <= 1'b0;
      d4_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      d1_vld_r  <= div_vld_out;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
      d4_vld_r  <= d3_vld_r;
      fin_vld_r <= d4_vld_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m1_r  <= s1_m1_nxt[31:0];
      s1_dd_r  <= s1_dd_nxt[31:0];
      s1_skt_r <= (in_rt == RAW_SKIP24);
      s1_skp_r <= (in_rp == RAW_SKIP24);
      s1_skh_r <= (in_rh == RAW_SKIP16);
      s1_rp_r  <= in_rp[23:4];
      s1_rh_r  <= in_rh;

      s2_v1_r  <= $signed(s1_m1_r[31:11]);
      s2_m2_r  <= s2_m2_nxt[31:0];
      s2_skt_r <= s1_skt_r;
      s2_skp_r <= s1_skp_r;
      s2_skh_r <= s1_skh_r;
      s2_rp_r  <= s1_rp_r;
      s2_rh_r  <= s1_rh_r;

      s3_tf_r  <= s3_tf_nxt;
      s3_skp_r <= s2_skp_r;
      s3_skh_r <= s2_skh_r;
      s3_rp_r  <= s2_rp_r;
      s3_rh_r  <= s2_rh_r;

      s4_temp_r <= s4_t5[23:8];
      s4_aa_r   <= s4_aa;
      s4_ap5_r  <= s4_ap5;
      s4_ap2_r  <= s4_ap2;
      s4_hv5_r  <= s4_hv5[31:0];
      s4_vh6_r  <= s4_vh6;
      s4_vh3_r  <= s4_vh3;
      s4_skp_r  <= s3_skp_r;
      s4_skh_r  <= s3_skh_r;
      s4_rp_r   <= s3_rp_r;
      s4_rh_r   <= s3_rh_r;

      s5_temp_r <= s4_temp_r;
      s5_b1_r   <= s5_b1;
      s5_c1_r   <= s5_c1;
      s5_ap5_r  <= s4_ap5_r;
      s5_ap2_r  <= s4_ap2_r;
      s5_ha_r   <= $signed(s5_hsum[31:15]);
      s5_hb1_r  <= s5_hb1[31:0];
      s5_skp_r  <= s4_skp_r;
      s5_skh_r  <= s4_skh_r;
      s5_rp_r   <= s4_rp_r;

      s6_temp_r <= s5_temp_r;
      s6_b_r    <= s6_b;
      s6_a2_r   <= s6_a2;
      s6_hm_r   <= s6_hm[31:0];
      s6_ha_r   <= s5_ha_r;
      s6_skp_r  <= s5_skp_r;
      s6_skh_r  <= s5_skh_r;
      s6_rp_r   <= s5_rp_r;

      s7_temp_r <= s6_temp_r;
      s7_a3_r   <= s7_a3[63:0];
      s7_num_r  <= s7_num;
      s7_hv_r   <= s7_hv[31:0];
      s7_skp_r  <= s6_skp_r;
      s7_skh_r  <= s6_skh_r;

      s8_temp_r <= s7_temp_r;
      s8_numm_r <= s8_numm;
      s8_den_r  <= s7_a3_r[63:33];
      s8_st_r   <= s8_st;
      s8_qq_r   <= s8_qq[31:0];
      s8_hv_r   <= s7_hv_r;
      s8_skh_r  <= s7_skh_r;

      s9_temp_r <= s8_temp_r;
      s9_numm_r <= s8_numm_r;
      s9_den_r  <= s8_den_r;
      s9_st_r   <= s8_st_r;
      s9_r_r    <= s9_r[31:0];
      s9_hv_r   <= s8_hv_r;
      s9_skh_r  <= s8_skh_r;

      d1_p_r    <= div_quot;
      d1_side_r <= div_side_out;

      d2_p_r    <= d1_p_r;
      d2_m_r    <= d2_m[63:0];
      d2_pb_r   <= d2_pb[63:0];
      d2_side_r <= d1_side_r;

      d3_p_r    <= d2_p_r;
      d3_ll_r   <= d3_ll;
      d3_c1_r   <= d3_c1;
      d3_c2_r   <= d3_c2;
      d3_bb_r   <= d2_pb_r[63:19];
      d3_side_r <= d2_side_r;

      d4_p_r    <= d3_p_r;
      d4_m2_r   <= d4_m2_nxt;
      d4_bb_r   <= d3_bb_r;
      d4_side_r <= d3_side_r;

      fin_data_r <= {d4_side_r.status, d4_side_r.hum, d5_press, d4_side_r.temp};
    end
  end

  // output register and skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= fin_vld_r;
      end
    end else if (fin_vld_r && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : fin_data_r;
    end else if (!skid_valid_r) begin
      skid_data_r <= fin_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_status_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[63:62] != PST_OK) |-> (out_data_r[47:16] == 32'd0))
    else $error("pressure not zero with non-valid status");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[61:48] <= 14'd10000))
    else $error("humidity out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_vld_r)
    else $error("accepted item did not enter the pipeline");

endmodule
